// File: rtl/ecu_pkg.sv
// Shared types, constants and curve tables for the easing curve unit.
package ecu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SINE_N = 256;
   localparam int EXP_N = 256;
   localparam int SINE_K = $clog2(SINE_N);
   localparam int EXP_K = $clog2(EXP_N);
   localparam int UW = FRAC_BITS + 1;
   localparam int EW = 16;
   localparam int VW = 16;
   localparam int OVW = 15;
   localparam int CSR_AW = 3;
   localparam int CSR_DW = 16;
   localparam int QDEPTH = 4;
   localparam int QAW = $clog2(QDEPTH);
   localparam logic [UW-1:0] ONE = UW'(1) << FRAC_BITS;
   localparam logic signed [VW-1:0] VAL_MAX = 16'sh7fff;
   localparam logic signed [VW-1:0] VAL_MIN = 16'sh8000;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint LN2_Q30 = 64'sd744261118;
   localparam longint Q30_ONE = 64'sd1 << 30;

   typedef enum logic [3:0] {
      CRV_LINEAR, CRV_IN_QUAD, CRV_OUT_QUAD, CRV_IN_SINE, CRV_OUT_SINE,
      CRV_IN_EXPO, CRV_OUT_EXPO, CRV_IN_BACK, CRV_OUT_BACK
   } curve_type;

   typedef enum logic [CSR_AW-1:0] {
      REG_CURVE, REG_START, REG_CHANGE, REG_DURATION, REG_OVERSHOOT
   } csr_index_type;

   typedef struct packed {
      logic [3:0]               curve;
      logic signed [VW-1:0]     start_value;
      logic signed [VW-1:0]     change_value;
      logic [EW-1:0]            duration;
      logic [OVW-1:0]           overshoot;
   } cfg_type;

   typedef logic [31:0] sine_tab_type [0:SINE_N];
   typedef logic [31:0] exp_tab_type [0:EXP_N];

   // quotient truncated toward zero, shift and subtract, table setup only
   function automatic longint div_trunc(longint num, longint den);
      longint unsigned n, d, q, r;
      bit neg;
      neg = (num < 0) != (den < 0);
      n = (num < 0) ? -num : num;
      d = (den < 0) ? -den : den;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         if (r >= d) begin
            r = r - d;
            q[b] = 1'b1;
         end
      end
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic sine_tab_type build_sine();
      sine_tab_type t;
      longint x, x2, term, sum;
      for (int i = 0; i <= SINE_N; i++) begin
         x = (HALF_PI_Q30 * longint'(i)) / SINE_N;
         x2 = (x * x) / Q30_ONE;
         term = x;
         sum = x;
         for (int k = 1; k <= 12; k++) begin
            term = (term * x2) / Q30_ONE;
            term = div_trunc(-term, longint'(2 * k) * longint'(2 * k + 1));
            sum = sum + term;
         end
         if (sum < 0) sum = 0;
         if (sum > Q30_ONE) sum = Q30_ONE;
         t[i] = 32'(sum);
      end
      return t;
   endfunction

   function automatic exp_tab_type build_exp();
      exp_tab_type t;
      longint unsigned y, term, sum;
      for (int i = 0; i <= EXP_N; i++) begin
         y = (longint'(LN2_Q30) * longint'(i)) / EXP_N;
         term = 64'd1 << 30;
         sum = term;
         for (int k = 1; k <= 20; k++) begin
            term = div_trunc(longint'((term * y) >> 30), longint'(k));
            sum = sum + term;
         end
         t[i] = 32'(sum);
      end
      return t;
   endfunction

   localparam sine_tab_type SINE_TAB = build_sine();
   localparam exp_tab_type EXP_TAB = build_exp();

endpackage

// File: rtl/ecu_if.sv
// Request, response and register-write channel interfaces.
interface ecu_req_if;
   import ecu_pkg::*;
   logic          valid;
   logic          ready;
   logic [EW-1:0] elapsed;
   modport source (output valid, output elapsed, input ready);
   modport sink (input valid, input elapsed, output ready);
endinterface

interface ecu_rsp_if;
   import ecu_pkg::*;
   logic                 valid;
   logic                 ready;
   logic signed [VW-1:0] value;
   logic                 clipped;
   modport source (output valid, output value, output clipped, input ready);
   modport sink (input valid, input value, input clipped, output ready);
endinterface

interface ecu_csr_if;
   import ecu_pkg::*;
   logic              valid;
   logic              ready;
   logic [CSR_AW-1:0] index;
   logic [CSR_DW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/ecu_front.sv
// Front end: clamps elapsed time and normalizes it by a pipelined restoring divider.
module ecu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  ecu_pkg::cfg_type         cfg,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [ecu_pkg::EW-1:0]   in_elapsed,
   output logic                     push,
   output logic [ecu_pkg::UW-1:0]   push_data,
   input  logic                     full
);
   import ecu_pkg::*;

   localparam int LAST = FRAC_BITS + 1;

   logic [EW-1:0] dur;
   logic          en;
   logic [LAST:0] vld_ff;
   logic [EW-1:0] rem_ff [0:LAST];
   logic [EW-1:0] rem_in [0:LAST];
   logic [UW-1:0] quo_ff [0:LAST];
   logic [UW-1:0] quo_in [0:LAST];
   logic [EW:0]   part;
   logic          ge;

   assign dur = (cfg.duration == '0) ? EW'(1) : cfg.duration;
   assign push = vld_ff[LAST] && !full;
   assign en = !vld_ff[LAST] || !full;
   assign in_ready = en;
   assign push_data = quo_ff[LAST];

   always_comb begin
      part = '0;
      ge = 1'b0;
      rem_in[0] = (in_elapsed > dur) ? dur : in_elapsed;
      quo_in[0] = '0;
      for (int k = 1; k <= LAST; k++) begin
         part = (k == 1) ? {1'b0, rem_ff[k-1]} : {rem_ff[k-1], 1'b0};
         ge = part >= {1'b0, dur};
         rem_in[k] = ge ? EW'(part - {1'b0, dur}) : EW'(part);
         quo_in[k] = {quo_ff[k-1][UW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAST-1:0], in_valid};
      end
      if (en) begin
         for (int k = 0; k <= LAST; k++) begin
            rem_ff[k] <= rem_in[k];
            quo_ff[k] <= quo_in[k];
         end
      end
   end

endmodule

// File: rtl/ecu_queue.sv
// Short queue of normalized times between the front and back ends.
module ecu_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [ecu_pkg::UW-1:0] push_data,
   input  logic                   pop,
   output logic [ecu_pkg::UW-1:0] pop_data,
   output logic                   full,
   output logic                   empty
);
   import ecu_pkg::*;

   logic [UW-1:0]  mem_ff [0:QDEPTH-1];
   logic [QAW-1:0] wr_ptr_ff;
   logic [QAW-1:0] rd_ptr_ff;
   logic [QAW:0]   count_ff;

   assign full = count_ff == (QAW+1)'(QDEPTH);
   assign empty = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_data;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QAW+1)'(QDEPTH)) else $error("queue count overflow");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1) else $error("push lost");
   a_count_down: assert property (@(posedge clock) disable iff (reset)
      pop && !push |=> count_ff == $past(count_ff) - 1'b1) else $error("pop lost");

endmodule

// File: rtl/ecu_back.sv
// Back end: curve evaluation, scaling by change, offset and saturation.
module ecu_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ecu_pkg::cfg_type              cfg,
   input  logic [ecu_pkg::UW-1:0]        u_in,
   input  logic                          empty,
   output logic                          pop,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic signed [ecu_pkg::VW-1:0] out_value,
   output logic                          out_clipped
);
   import ecu_pkg::*;

   localparam int F = FRAC_BITS;
   localparam int MW = F + 2;
   localparam int SW = F + 3;
   localparam int XW = F + 4;
   localparam int SPW = 34 + F;
   localparam int SSW = 34;
   localparam int CW = F + 8;
   localparam int PW = VW + CW;
   localparam int RW = PW - F + 1;

   logic [6:1] vld_ff;
   logic       en;

   // stage 1
   logic [UW-1:0]        om, p_sin;
   logic [SINE_K:0]      sidx;
   logic [31:0]          s_lo, s_hi, e_lo, e_hi;
   logic [XW-1:0]        xe;
   logic [EXP_K-1:0]     eidx;
   logic [2*UW-1:0]      sq_u, sq_m;
   logic [UW-1:0]        u1_ff, om1_ff, u2a_ff, m2a_ff;
   logic [31:0]          slo1_ff, elo1_ff;
   logic signed [32:0]   sdiff1_ff, ediff1_ff;
   logic [F-1:0]         srem1_ff, erem1_ff;
   logic [3:0]           eip1_ff;

   // stage 2
   logic [2*UW-1:0]      p_u3, p_m3;
   logic signed [2*UW:0] m_neg;
   logic [UW-1:0]        u2_ff, u2b_ff, u3_ff, m2b_ff;
   logic signed [MW-1:0] m3_ff;
   logic [31:0]          slo2_ff, elo2_ff;
   logic signed [SPW-1:0] sprod_ff, eprod_ff;
   logic [3:0]           eip2_ff;

   // stage 3
   logic [SW-1:0]        s_val;
   logic [OVW+F-1:0]     ov_ext;
   logic [SW:0]          c3_val;
   logic [2*F+4:0]       p7a;
   logic [2*F+3:0]       p7b, p8b;
   logic signed [2*F+6:0] p8a;
   logic signed [SSW-1:0] ssum, esum;
   logic [5:0]           shamt;
   logic [UW-1:0]        u3s_ff, u2c_ff, sv_ff, ev_ff;
   logic [F+4:0]         a7_ff;
   logic [F+3:0]         b7_ff, b8_ff;
   logic signed [F+6:0]  a8_ff;

   // stage 4..6
   logic signed [CW-1:0] c_in, c_ff;
   logic signed [PW-1:0] prod_ff, rnd;
   logic signed [RW-1:0] total;
   logic signed [VW-1:0] value_in, value_ff;
   logic                 clip_in, clip_ff;

   assign en = !vld_ff[6] || out_ready;
   assign pop = en && !empty;
   assign out_valid = vld_ff[6];
   assign out_value = value_ff;
   assign out_clipped = clip_ff;

   always_comb begin
      om = ONE - u_in;
      p_sin = (cfg.curve == CRV_IN_SINE) ? om : u_in;
      sidx = p_sin[F -: (SINE_K + 1)];
      if (sidx >= (SINE_K+1)'(SINE_N)) begin
         s_lo = SINE_TAB[SINE_N];
         s_hi = SINE_TAB[SINE_N];
      end else begin
         s_lo = SINE_TAB[sidx];
         s_hi = SINE_TAB[sidx + 1'b1];
      end
      xe = (cfg.curve == CRV_IN_EXPO) ? XW'(u_in) * XW'(10) : XW'(om) * XW'(10);
      eidx = xe[F-1 -: EXP_K];
      e_lo = EXP_TAB[eidx];
      e_hi = EXP_TAB[{1'b0, eidx} + 1'b1];
      sq_u = (2*UW)'(u_in) * (2*UW)'(u_in);
      sq_m = (2*UW)'(om) * (2*UW)'(om);
   end

   always_comb begin
      p_u3 = (2*UW)'(u2a_ff) * (2*UW)'(u1_ff);
      p_m3 = (2*UW)'(m2a_ff) * (2*UW)'(om1_ff);
      m_neg = -$signed({1'b0, p_m3});
   end

   always_comb begin
      ov_ext = {cfg.overshoot, {F{1'b0}}};
      s_val = ov_ext[OVW+F-1:12];
      c3_val = (SW+1)'(s_val) + (SW+1)'(ONE);
      p7a = (2*F+5)'(c3_val) * (2*F+5)'(u3_ff);
      p7b = (2*F+4)'(s_val) * (2*F+4)'(u2b_ff);
      p8a = $signed((2*F+7)'({1'b0, c3_val})) * (2*F+7)'(m3_ff);
      p8b = (2*F+4)'(s_val) * (2*F+4)'(m2b_ff);
      ssum = $signed(SSW'(slo2_ff)) + SSW'(sprod_ff >>> F);
      esum = $signed(SSW'(elo2_ff)) + SSW'(eprod_ff >>> F);
      shamt = 6'(40 - F) - 6'(eip2_ff);
   end

   always_comb begin
      case (cfg.curve)
         CRV_IN_QUAD:  c_in = CW'($signed({1'b0, u2c_ff}));
         CRV_OUT_QUAD: c_in = CW'($signed({1'b0, u3s_ff, 1'b0})) - CW'($signed({1'b0, u2c_ff}));
         CRV_IN_SINE:  c_in = CW'($signed({1'b0, ONE})) - CW'($signed({1'b0, sv_ff}));
         CRV_OUT_SINE: c_in = CW'($signed({1'b0, sv_ff}));
         CRV_IN_EXPO:  c_in = CW'($signed({1'b0, ev_ff}));
         CRV_OUT_EXPO: c_in = CW'($signed({1'b0, ONE})) - CW'($signed({1'b0, ev_ff}));
         CRV_IN_BACK:  c_in = CW'($signed({1'b0, a7_ff})) - CW'($signed({1'b0, b7_ff}));
         CRV_OUT_BACK: c_in = CW'($signed({1'b0, ONE})) + CW'(a8_ff)
                              + CW'($signed({1'b0, b8_ff}));
         default:      c_in = CW'($signed({1'b0, u3s_ff}));
      endcase
   end

   always_comb begin
      rnd = (prod_ff + $signed(PW'(ONE >> 1))) >>> F;
      total = RW'(cfg.start_value) + RW'(rnd);
      clip_in = 1'b0;
      value_in = VW'(total);
      if (total > RW'(VAL_MAX)) begin
         value_in = VAL_MAX;
         clip_in = 1'b1;
      end else if (total < RW'(VAL_MIN)) begin
         value_in = VAL_MIN;
         clip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[5:1], pop};
      end
      if (en) begin
         u1_ff <= u_in;
         om1_ff <= om;
         u2a_ff <= sq_u[F +: UW];
         m2a_ff <= sq_m[F +: UW];
         slo1_ff <= s_lo;
         sdiff1_ff <= $signed({1'b0, s_hi}) - $signed({1'b0, s_lo});
         srem1_ff <= {p_sin[F-SINE_K-1:0], {SINE_K{1'b0}}};
         elo1_ff <= e_lo;
         ediff1_ff <= $signed({1'b0, e_hi}) - $signed({1'b0, e_lo});
         erem1_ff <= {xe[F-EXP_K-1:0], {EXP_K{1'b0}}};
         eip1_ff <= xe[F +: 4];

         u2_ff <= u1_ff;
         u2b_ff <= u2a_ff;
         u3_ff <= p_u3[F +: UW];
         m2b_ff <= m2a_ff;
         m3_ff <= MW'(m_neg >>> F);
         slo2_ff <= slo1_ff;
         elo2_ff <= elo1_ff;
         sprod_ff <= SPW'(sdiff1_ff) * SPW'($signed({1'b0, srem1_ff}));
         eprod_ff <= SPW'(ediff1_ff) * SPW'($signed({1'b0, erem1_ff}));
         eip2_ff <= eip1_ff;

         u3s_ff <= u2_ff;
         u2c_ff <= u2b_ff;
         sv_ff <= ssum[30-F +: UW];
         ev_ff <= UW'($unsigned(esum) >> shamt);
         a7_ff <= p7a[2*F+4:F];
         b7_ff <= p7b[2*F+3:F];
         a8_ff <= $signed(p8a[2*F+6:F]);
         b8_ff <= p8b[2*F+3:F];

         c_ff <= c_in;
         prod_ff <= PW'(cfg.change_value) * PW'(c_ff);
         value_ff <= value_in;
         clip_ff <= clip_in;
      end
   end

endmodule

// File: rtl/easing_curve_unit.sv
// Top level of the easing curve unit: registers, front end, queue, back end.
//
// Usage: configure curve, start_value, change_value, duration and overshoot
// through csr_bus (index 0..4, always ready) while no request is in flight.
// Each request on req_bus carries an elapsed tick count; each gives exactly
// one response on rsp_bus with the eased value and a saturation flag.
// An accepted request passes through the divider that forms normalized
// time (a clamp stage, then one quotient bit per stage), the queue and
// the curve and scaling pipeline before its response. Throughput is one
// request per cycle while rsp_bus does not stall, set by the divider and
// curve pipelines, each of which advances whenever it is not held.
// When rsp_bus stalls, the back pipeline holds, the queue fills, then the
// front pipeline holds and req_bus.ready drops; no request is lost.
// Reset clears all pipelines and the queue and returns the registers to
// linear, start 0, change 0, duration 1, overshoot 6970.
module easing_curve_unit (
   input logic        clock,
   input logic        reset,
   ecu_req_if.sink    req_bus,
   ecu_rsp_if.source  rsp_bus,
   ecu_csr_if.sink    csr_bus
);
   import ecu_pkg::*;

   logic [3:0]           curve_ff;
   logic signed [VW-1:0] start_ff;
   logic signed [VW-1:0] change_ff;
   logic [EW-1:0]        duration_ff;
   logic [OVW-1:0]       overshoot_ff;
   cfg_type              cfg;
   logic                 push, pop, full, empty;
   logic [UW-1:0]        push_data, pop_data;

   assign csr_bus.ready = 1'b1;
   assign cfg = '{curve: curve_ff, start_value: start_ff, change_value: change_ff,
                  duration: duration_ff, overshoot: overshoot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_ff <= 4'(CRV_LINEAR);
         start_ff <= '0;
         change_ff <= '0;
         duration_ff <= EW'(1);
         overshoot_ff <= OVW'(6970);
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            REG_CURVE:     curve_ff <= csr_bus.data[3:0];
            REG_START:     start_ff <= $signed(csr_bus.data);
            REG_CHANGE:    change_ff <= $signed(csr_bus.data);
            REG_DURATION:  duration_ff <= csr_bus.data;
            REG_OVERSHOOT: overshoot_ff <= csr_bus.data[OVW-1:0];
            default: ;
         endcase
      end
   end

   ecu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .in_valid   (req_bus.valid),
      .in_ready   (req_bus.ready),
      .in_elapsed (req_bus.elapsed),
      .push       (push),
      .push_data  (push_data),
      .full       (full)
   );

   ecu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .full      (full),
      .empty     (empty)
   );

   ecu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .u_in        (pop_data),
      .empty       (empty),
      .pop         (pop),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .out_value   (rsp_bus.value),
      .out_clipped (rsp_bus.clipped)
   );

endmodule
